/* rtl/fcp_pkg.sv */
// Shared types and constants for the frame chunk packetizer.
// Used by fcp_cfg_regs, fcp_framer and frame_chunk_packetizer; no dependencies.
`default_nettype none

package fcp_pkg;

  // Register field widths
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned FILL_W  = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Largest payload a packet may carry
  localparam logic [LEN_W-1:0] MAX_PAYLOAD  = LEN_W'(4096);
  localparam int unsigned      HEADER_BYTES = 8;
  localparam int unsigned      HDR_CNT_W    = $clog2(HEADER_BYTES) + 1;

  // Register reset values
  localparam logic [LEN_W-1:0] PAYLOAD_SIZE_RST = LEN_W'(4096);
  localparam logic [CNT_W-1:0] CHUNK_TOTAL_RST  = CNT_W'(27);
  localparam logic [LEN_W-1:0] LAST_PAYLOAD_RST = LEN_W'(2304);

  // Header bytes
  localparam logic [BYTE_W-1:0] SYNC0     = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC1     = 8'hA3;
  localparam logic [BYTE_W-1:0] CMD_FIRST = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_MID   = 8'hF1;
  localparam logic [BYTE_W-1:0] CMD_LAST  = 8'hF2;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_PAYLOAD_SIZE = 2'd0,
    REG_CHUNK_TOTAL  = 2'd1,
    REG_LAST_PAYLOAD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] payload_size;
    logic [CNT_W-1:0] chunk_total;
    logic [LEN_W-1:0] last_payload;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              packet_start;
    logic              packet_end;
    logic [FILL_W-1:0] zero_fill;
    logic              frame_end;
    logic              last;
  } result_t;

  // Zero acts as one, oversize acts as the maximum payload
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > MAX_PAYLOAD) begin
      r = MAX_PAYLOAD;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Header byte at a given position
  function automatic logic [BYTE_W-1:0] hdr_byte(
    input logic [HDR_CNT_W-2:0] idx,
    input logic [BYTE_W-1:0]    cmd,
    input logic [BYTE_W-1:0]    seq
  );
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = SYNC0;
      3'd1:    b = SYNC1;
      3'd2:    b = cmd;
      3'd3:    b = seq;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/frame_chunk_packetizer.sv */
// Frame chunk packetizer: splits a frame byte stream into headed packets.
// Top level; instantiates fcp_cfg_regs and fcp_framer, uses fcp_pkg.
//
// Usage: frame bytes enter on the in_ channel (valid/ready), one byte per
// transaction. Each byte leaves on the out_ channel as one data transaction,
// preceded by the eight header bytes (55 A3 cmd seq 00 00 00 00) when it
// opens a packet. out_last marks the final transaction caused by an input
// byte; out_packet_end, out_zero_fill and out_frame_end are set on the last
// data byte of a packet or frame. Padding is never sent, only counted.
// An input byte passes the holding register and then the result register; a
// byte that opens a packet follows its eight header bytes, while in_ready is
// low. It sends one output transaction per cycle while out_ready is high:
// one input byte per cycle inside a packet. A one-entry holding register and
// the output register keep in_ready high while a finished result waits; a
// stalled receiver holds the output and, once the holding register is full,
// deasserts in_ready. Reset (rst_n low, synchronous) loads payload_size
// 4096, chunk_total 27, last_payload 2304 and restarts at the first packet
// of a frame. Registers are written through the APB port at 0x0, 0x4 and
// 0x8; the user must write them only while idle; the block has no check.
`default_nettype none

module frame_chunk_packetizer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fcp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [fcp_pkg::DATA_W-1:0]   pwdata,
  output logic      [fcp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  // input bytes
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_pixel_byte,
  // packet stream
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_packet_start,
  output logic                              out_packet_end,
  output logic [11:0]                       out_zero_fill,
  output logic                              out_frame_end,
  output logic                              out_last
);

  fcp_pkg::cfg_t    cfg;
  fcp_pkg::result_t res;

  fcp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcp_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_pixel_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_byte         = res.out_byte;
  assign out_packet_start = res.packet_start;
  assign out_packet_end   = res.packet_end;
  assign out_zero_fill    = res.zero_fill;
  assign out_frame_end    = res.frame_end;
  assign out_last         = res.last;

endmodule

`default_nettype wire

/* rtl/fcp_cfg_regs.sv */
// APB-style configuration registers of the packetizer.
// Depends on fcp_pkg for widths, reset values and register indexes.
`default_nettype none

module fcp_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fcp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [fcp_pkg::DATA_W-1:0]   pwdata,
  output logic      [fcp_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output fcp_pkg::cfg_t                     cfg
);

  fcp_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        fcp_pkg::REG_PAYLOAD_SIZE: cfg_nxt.payload_size = pwdata[fcp_pkg::LEN_W-1:0];
        fcp_pkg::REG_CHUNK_TOTAL:  cfg_nxt.chunk_total  = pwdata[fcp_pkg::CNT_W-1:0];
        fcp_pkg::REG_LAST_PAYLOAD: cfg_nxt.last_payload = pwdata[fcp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.payload_size <= fcp_pkg::PAYLOAD_SIZE_RST;
      cfg_r.chunk_total  <= fcp_pkg::CHUNK_TOTAL_RST;
      cfg_r.last_payload <= fcp_pkg::LAST_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      fcp_pkg::REG_PAYLOAD_SIZE: prdata = fcp_pkg::DATA_W'(cfg_r.payload_size);
      fcp_pkg::REG_CHUNK_TOTAL:  prdata = fcp_pkg::DATA_W'(cfg_r.chunk_total);
      fcp_pkg::REG_LAST_PAYLOAD: prdata = fcp_pkg::DATA_W'(cfg_r.last_payload);
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/fcp_framer.sv */
// Packet framing datapath: input holding register, chunk state, header
// sequencing and result register. Depends on fcp_pkg.
`default_nettype none

module fcp_framer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fcp_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [fcp_pkg::BYTE_W-1:0]  in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output fcp_pkg::result_t                 out_res
);

  // Input holding register
  logic                          hold_v_r, hold_v_nxt;
  logic [fcp_pkg::BYTE_W-1:0]    hold_d_r, hold_d_nxt;

  // Chunk state
  logic [fcp_pkg::CNT_W-1:0]     chunk_idx_r, chunk_idx_nxt;
  logic [fcp_pkg::LEN_W-1:0]     byte_cnt_r, byte_cnt_nxt;
  logic [fcp_pkg::HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;

  // Result register
  logic                          out_v_r, out_v_nxt;
  fcp_pkg::result_t              res_r, res_nxt;

  logic                          adv, emit_hdr, emit_dat, fire;
  logic [fcp_pkg::LEN_W-1:0]     full, len, last_len;
  logic [fcp_pkg::CNT_W-1:0]     total;
  logic                          is_last, pkt_done;
  logic [fcp_pkg::BYTE_W-1:0]    cmd, seq;
  logic [fcp_pkg::LEN_W-1:0]     fill;

  // Packet geometry for the current chunk
  always_comb begin
    full     = fcp_pkg::eff_len(cfg.payload_size);
    total    = (cfg.chunk_total == '0) ? fcp_pkg::CNT_W'(1) : cfg.chunk_total;
    is_last  = chunk_idx_r >= (total - fcp_pkg::CNT_W'(1));
    last_len = fcp_pkg::eff_len(cfg.last_payload);
    len      = full;
    if (is_last && (last_len < full)) begin
      len = last_len;
    end
    // full never exceeds MAX_PAYLOAD and len is at least 1: fill fits 12 bits
    fill     = full - len;
    pkt_done = ({1'b0, byte_cnt_r} + (fcp_pkg::LEN_W+1)'(1)) >= {1'b0, len};
    if (chunk_idx_r == '0) begin
      cmd = fcp_pkg::CMD_FIRST;
    end else if (is_last) begin
      cmd = fcp_pkg::CMD_LAST;
    end else begin
      cmd = fcp_pkg::CMD_MID;
    end
    seq = chunk_idx_r + fcp_pkg::CNT_W'(1);
  end

  // Handshake and sequencing
  always_comb begin
    adv      = !out_v_r || out_ready;
    emit_hdr = hold_v_r && (byte_cnt_r == '0) && !hdr_cnt_r[fcp_pkg::HDR_CNT_W-1];
    emit_dat = hold_v_r && !emit_hdr;
    fire     = adv && hold_v_r;
    in_ready = !hold_v_r || (adv && emit_dat);
  end

  // Next state
  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_d_nxt    = hold_d_r;
    chunk_idx_nxt = chunk_idx_r;
    byte_cnt_nxt  = byte_cnt_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    out_v_nxt     = out_v_r;
    res_nxt       = res_r;

    if (fire && emit_dat) begin
      hold_v_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_v_nxt = 1'b1;
      hold_d_nxt = in_data;
    end

    if (adv) begin
      out_v_nxt = hold_v_r;
    end

    if (fire) begin
      if (emit_hdr) begin
        res_nxt.out_byte     = fcp_pkg::hdr_byte(hdr_cnt_r[fcp_pkg::HDR_CNT_W-2:0], cmd, seq);
        res_nxt.packet_start = (hdr_cnt_r == '0);
        res_nxt.packet_end   = 1'b0;
        res_nxt.zero_fill    = '0;
        res_nxt.frame_end    = 1'b0;
        res_nxt.last         = 1'b0;
        hdr_cnt_nxt          = hdr_cnt_r + fcp_pkg::HDR_CNT_W'(1);
      end else begin
        res_nxt.out_byte     = hold_d_r;
        res_nxt.packet_start = 1'b0;
        res_nxt.packet_end   = pkt_done;
        res_nxt.zero_fill    = pkt_done ? fill[fcp_pkg::FILL_W-1:0] : '0;
        res_nxt.frame_end    = pkt_done && is_last;
        res_nxt.last         = 1'b1;
        hdr_cnt_nxt          = '0;
        if (pkt_done) begin
          byte_cnt_nxt  = '0;
          chunk_idx_nxt = is_last ? '0 : (chunk_idx_r + fcp_pkg::CNT_W'(1));
        end else begin
          byte_cnt_nxt  = byte_cnt_r + fcp_pkg::LEN_W'(1);
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      chunk_idx_r <= '0;
      byte_cnt_r  <= '0;
      hdr_cnt_r   <= '0;
      out_v_r     <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      chunk_idx_r <= chunk_idx_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hold_d_r <= hold_d_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for frame_chunk_packetizer: a directed table, then random frames.
// Depends on fcp_pkg and the RTL; expected packet bytes come from an in-file predictor.
module tb;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam int unsigned REPORT_MAX    = 10;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  // One directed step: a register write or an input byte, optionally with
  // the data transaction's expected flags typed in
  typedef struct {
    row_kind_t                      kind;
    fcp_pkg::reg_idx_t              ridx;
    logic [fcp_pkg::DATA_W-1:0]     val;
    logic [7:0]                     px;
    bit                             typed;
    bit                             pend;
    logic [fcp_pkg::FILL_W-1:0]     fill;
    bit                             fend;
  } script_row_t;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [fcp_pkg::ADDR_W-1:0] paddr         = '0;
  logic [fcp_pkg::DATA_W-1:0] pwdata        = '0;
  logic [fcp_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic [7:0]                 in_pixel_byte = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic [7:0]                 out_byte;
  logic                       out_packet_start;
  logic                       out_packet_end;
  logic [11:0]                out_zero_fill;
  logic                       out_frame_end;
  logic                       out_last;

  // Predictor state: register shadow and packet position
  fcp_pkg::cfg_t              shadow = '{fcp_pkg::PAYLOAD_SIZE_RST, fcp_pkg::CHUNK_TOTAL_RST,
                                         fcp_pkg::LAST_PAYLOAD_RST};
  logic [fcp_pkg::CNT_W-1:0]  chunk_idx = '0;
  logic [fcp_pkg::LEN_W-1:0]  byte_cnt  = '0;
  fcp_pkg::result_t           pending_stream[$];

  int unsigned                mismatches = 0;
  int unsigned                cycles     = 0;
  logic                       calm       = 1'b0;

  frame_chunk_packetizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_byte    (in_pixel_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_packet_start (out_packet_start),
    .out_packet_end   (out_packet_end),
    .out_zero_fill    (out_zero_fill),
    .out_frame_end    (out_frame_end),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stalls, off during calm stretches
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  // Zero length acts as one, oversize as the maximum payload
  function automatic int unsigned clamp_len(input logic [fcp_pkg::LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > fcp_pkg::MAX_PAYLOAD) return int'(fcp_pkg::MAX_PAYLOAD);
    return int'(v);
  endfunction

  // Expected packet stream for one accepted frame byte
  task automatic packetize_byte(input logic [7:0] px);
    int unsigned      full;
    int unsigned      total;
    int unsigned      len;
    bit               at_end;
    logic [7:0]       cmd;
    fcp_pkg::result_t r;
    full   = clamp_len(shadow.payload_size);
    total  = (shadow.chunk_total == '0) ? 1 : int'(shadow.chunk_total);
    at_end = chunk_idx >= total - 1;
    len    = at_end ? clamp_len(shadow.last_payload) : full;
    if (len > full) len = full;
    // header ahead of a packet's first data byte
    if (byte_cnt == '0) begin
      cmd = (chunk_idx == '0) ? fcp_pkg::CMD_FIRST :
            (at_end ? fcp_pkg::CMD_LAST : fcp_pkg::CMD_MID);
      for (int i = 0; i < fcp_pkg::HEADER_BYTES; i++) begin
        r = '0;
        case (i)
          0:       r.out_byte = fcp_pkg::SYNC0;
          1:       r.out_byte = fcp_pkg::SYNC1;
          2:       r.out_byte = cmd;
          3:       r.out_byte = chunk_idx + 8'd1;
          default: r.out_byte = '0;
        endcase
        r.packet_start = (i == 0);
        pending_stream.push_back(r);
      end
    end
    // data byte; padding is only counted on a packet's last byte
    r = '0;
    r.out_byte = px;
    r.last     = 1'b1;
    if (byte_cnt + 1 >= len) begin
      r.packet_end = 1'b1;
      r.zero_fill  = (full - len > 4095) ? 12'd4095 : fcp_pkg::FILL_W'(full - len);
      r.frame_end  = at_end;
      byte_cnt     = '0;
      chunk_idx    = at_end ? '0 : chunk_idx + 8'd1;
    end else begin
      byte_cnt = byte_cnt + 1'b1;
    end
    pending_stream.push_back(r);
  endtask

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    fcp_pkg::result_t got;
    fcp_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte, out_packet_start, out_packet_end, out_zero_fill,
              out_frame_end, out_last};
      if (pending_stream.size() == 0) begin
        report_mismatch($sformatf("unexpected byte=%02h start=%b end=%b fill=%0d fe=%b last=%b",
                        got.out_byte, got.packet_start, got.packet_end, got.zero_fill,
                        got.frame_end, got.last));
      end else begin
        want = pending_stream.pop_front();
        if (got.out_byte !== want.out_byte || got.packet_start !== want.packet_start ||
            got.packet_end !== want.packet_end || got.zero_fill !== want.zero_fill ||
            got.frame_end !== want.frame_end || got.last !== want.last) begin
          report_mismatch($sformatf({"byte mismatch: want %02h s%b e%b fill %0d fe%b l%b,",
                          " got %02h s%b e%b fill %0d fe%b l%b"},
                          want.out_byte, want.packet_start, want.packet_end,
                          want.zero_fill, want.frame_end, want.last,
                          got.out_byte, got.packet_start, got.packet_end,
                          got.zero_fill, got.frame_end, got.last));
        end
      end
    end
  end

  // APB write then read back; entered and left at a falling edge
  task automatic apb_write(input fcp_pkg::reg_idx_t idx,
                           input logic [fcp_pkg::DATA_W-1:0] data);
    logic [fcp_pkg::DATA_W-1:0] keep;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fcp_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      fcp_pkg::REG_PAYLOAD_SIZE: shadow.payload_size = data[fcp_pkg::LEN_W-1:0];
      fcp_pkg::REG_CHUNK_TOTAL:  shadow.chunk_total  = data[fcp_pkg::CNT_W-1:0];
      default:                   shadow.last_payload = data[fcp_pkg::LEN_W-1:0];
    endcase
    @(negedge clk) begin
      pwrite  <= 1'b0;
      penable <= 1'b0;
    end
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      fcp_pkg::REG_PAYLOAD_SIZE: keep = fcp_pkg::DATA_W'(shadow.payload_size);
      fcp_pkg::REG_CHUNK_TOTAL:  keep = fcp_pkg::DATA_W'(shadow.chunk_total);
      default:                   keep = fcp_pkg::DATA_W'(shadow.last_payload);
    endcase
    if (prdata !== keep)
      report_mismatch($sformatf("register %s reads %0h, want %0h", idx.name(), prdata, keep));
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    // stay idle before the next access
    @(negedge clk);
  endtask

  // Offer one byte with random gaps; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] px);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel_byte <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    packetize_byte(px);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected byte has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_stream.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic script_row_t mk_write(input fcp_pkg::reg_idx_t idx,
                                           input logic [fcp_pkg::DATA_W-1:0] v);
    script_row_t r;
    r.kind  = ROW_WRITE;
    r.ridx  = idx;
    r.val   = v;
    r.px    = '0;
    r.typed = 1'b0;
    r.pend  = 1'b0;
    r.fill  = '0;
    r.fend  = 1'b0;
    return r;
  endfunction

  function automatic script_row_t mk_byte(input logic [7:0] px, input bit typed,
                                          input bit pend,
                                          input logic [fcp_pkg::FILL_W-1:0] fill,
                                          input bit fend);
    script_row_t r;
    r.kind  = ROW_BYTE;
    r.ridx  = fcp_pkg::REG_PAYLOAD_SIZE;
    r.val   = '0;
    r.px    = px;
    r.typed = typed;
    r.pend  = pend;
    r.fill  = fill;
    r.fend  = fend;
    return r;
  endfunction

  // Random length value: mostly short, sometimes zero, maximum or oversize
  function automatic logic [fcp_pkg::LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return fcp_pkg::MAX_PAYLOAD;
      2:       return fcp_pkg::LEN_W'($urandom_range(4097, 8191));
      default: return fcp_pkg::LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    script_row_t                script[$];
    fcp_pkg::result_t           typed_res;
    logic [fcp_pkg::DATA_W-1:0] v;
    int unsigned                sent;
    int unsigned                phase;
    int unsigned                n;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset values: first packet opens with the first-packet command
    script.push_back(mk_byte(8'h00, 1'b1, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'hFF, 1'b1, 1'b0, 12'd0, 1'b0));
    // Zero registers act as one; count already past the new length ends the packet
    script.push_back(mk_write(fcp_pkg::REG_PAYLOAD_SIZE, 32'd0));
    script.push_back(mk_write(fcp_pkg::REG_CHUNK_TOTAL, 32'd3));
    script.push_back(mk_write(fcp_pkg::REG_LAST_PAYLOAD, 32'd0));
    script.push_back(mk_byte(8'hA5, 1'b1, 1'b1, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h5A, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h3C, 1'b1, 1'b1, 12'd0, 1'b1));
    // Oversize payload, single-packet frame, widest padding
    script.push_back(mk_write(fcp_pkg::REG_PAYLOAD_SIZE, 32'd8191));
    script.push_back(mk_write(fcp_pkg::REG_CHUNK_TOTAL, 32'd0));
    script.push_back(mk_write(fcp_pkg::REG_LAST_PAYLOAD, 32'd1));
    script.push_back(mk_byte(8'h80, 1'b1, 1'b1, 12'd4095, 1'b1));
    script.push_back(mk_byte(8'h7F, 1'b0, 1'b0, 12'd0, 1'b0));
    // Longest frame setting, last payload beyond payload size
    script.push_back(mk_write(fcp_pkg::REG_PAYLOAD_SIZE, 32'd2));
    script.push_back(mk_write(fcp_pkg::REG_CHUNK_TOTAL, 32'd255));
    script.push_back(mk_write(fcp_pkg::REG_LAST_PAYLOAD, 32'd8191));
    script.push_back(mk_byte(8'h01, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h02, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h04, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h08, 1'b0, 1'b0, 12'd0, 1'b0));
    // Shrinking the total leaves the index past it: next packet is the last
    script.push_back(mk_write(fcp_pkg::REG_CHUNK_TOTAL, 32'd2));
    script.push_back(mk_byte(8'h10, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h20, 1'b1, 1'b1, 12'd0, 1'b1));
    // Short last packet padded by two
    script.push_back(mk_write(fcp_pkg::REG_PAYLOAD_SIZE, 32'd5));
    script.push_back(mk_write(fcp_pkg::REG_LAST_PAYLOAD, 32'd3));
    for (int i = 0; i < 5; i++)
      script.push_back(mk_byte(8'(8'h40 + i), 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'hAA, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'h55, 1'b0, 1'b0, 12'd0, 1'b0));
    script.push_back(mk_byte(8'hC3, 1'b1, 1'b1, 12'd2, 1'b1));

    // Directed walk
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        apb_write(script[i].ridx, script[i].val);
      end else begin
        send_byte(script[i].px);
        if (script[i].typed) begin
          typed_res = '{script[i].px, 1'b0, script[i].pend, script[i].fill,
                        script[i].fend, 1'b1};
          pending_stream[$] = typed_res;
        end
      end
    end

    // Random frames under changing settings
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      calm <= (phase == 2);
      if (phase == 0 || $urandom_range(99) < 70) begin
        v = $urandom();
        v[fcp_pkg::LEN_W-1:0] = pick_len();
        apb_write(fcp_pkg::REG_PAYLOAD_SIZE, v);
      end
      if (phase == 0 || $urandom_range(99) < 70) begin
        v = $urandom();
        case ($urandom_range(9))
          0:       v[fcp_pkg::CNT_W-1:0] = '0;
          1:       v[fcp_pkg::CNT_W-1:0] = 8'd255;
          2:       v[fcp_pkg::CNT_W-1:0] = 8'd1;
          default: v[fcp_pkg::CNT_W-1:0] = fcp_pkg::CNT_W'($urandom_range(2, 6));
        endcase
        apb_write(fcp_pkg::REG_CHUNK_TOTAL, v);
      end
      if (phase == 0 || $urandom_range(99) < 70) begin
        v = $urandom();
        v[fcp_pkg::LEN_W-1:0] = pick_len();
        apb_write(fcp_pkg::REG_LAST_PAYLOAD, v);
      end
      n = $urandom_range(10, 25);
      for (int k = 0; k < n; k++) begin
        // hold off once until the block has drained completely
        if (phase == 1 && k == n / 2) settle();
        send_byte(8'($urandom_range(255)));
      end
      sent += n;
      phase++;
    end
    calm <= 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/fcp_pkg.sv
rtl/fcp_cfg_regs.sv
rtl/fcp_framer.sv
rtl/frame_chunk_packetizer.sv
tb/sv/tb.sv
